[src/rational_arithmetic_unit_assert.svh]
// Assertion macros for the rational arithmetic unit.
// Depends on nothing; included by the top level.
`ifndef RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH
`define RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define RAU_ASSERT_IMPL(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define RAU_ASSERT_RST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RAU_ASSERT_IMPL(label, clk, rstn, prop, msg)
`define RAU_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

[src/rau_pkg.sv]
// Package for the rational arithmetic unit: widths, opcodes, status, states.
// Depends on nothing.
`default_nettype none
package rau_pkg;
    localparam int OPERAND_WIDTH_DEF = 16;
    localparam int NUM_OUT_W = 33;
    localparam int DEN_OUT_W = 31;
    localparam int DIV_W = 64;

    typedef enum logic [1:0] {OP_ADD = 2'd0, OP_SUB = 2'd1, OP_MUL = 2'd2, OP_DIV = 2'd3} op_t;
    typedef enum logic [1:0] {ST_OK = 2'd0, ST_ZDEN = 2'd1, ST_DIVZ = 2'd2} status_t;

    typedef enum logic [3:0] {
        S_IDLE, S_RED_A, S_RED_B, S_FORM, S_RED_R, S_OUT
    } seq_state_t;

    typedef enum logic [2:0] {
        R_IDLE, R_EUC, R_DIVN, R_DIVNW, R_DIVD, R_DIVDW, R_DONE
    } red_state_t;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } div_ctl_t;
endpackage
`default_nettype wire

[src/rau_divider.sv]
// Shared restoring divider (one quotient bit per cycle), unsigned.
// Depends on rau_pkg.
`default_nettype none
module rau_divider #(
    parameter int W = rau_pkg::DIV_W
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         start,
    input  wire logic [W-1:0] dividend,
    input  wire logic [W-1:0] divisor,
    output logic              done,
    output logic [W-1:0]      quotient,
    output logic [W-1:0]      remainder
);
    localparam int CW = $clog2(W + 1);
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic [W-1:0]  q_reg, q_next;
    logic [W-1:0]  r_reg, r_next;
    logic [W-1:0]  d_reg, d_next;
    logic [W:0]    trial;
    logic          done_reg, done_next;

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        done_next = 1'b0;
        trial     = {r_reg, q_reg[W-1]} - {1'b0, d_reg};
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CW'(W);
            q_next    = dividend;
            r_next    = '0;
            d_next    = divisor;
        end else if (busy_reg) begin
            if (!trial[W]) begin
                r_next = trial[W-1:0];
                q_next = {q_reg[W-2:0], 1'b1};
            end else begin
                r_next = {r_reg[W-2:0], q_reg[W-1]};
                q_next = {q_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign done      = done_reg;
    assign quotient  = q_reg;
    assign remainder = r_reg;
endmodule
`default_nettype wire

[src/rau_reducer.sv]
// Fraction reducer: Euclid gcd then two divisions, all on the shared divider.
// Depends on rau_pkg and rau_divider.
`default_nettype none
module rau_reducer #(
    parameter int W = rau_pkg::DIV_W
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         start,
    input  wire logic [W-1:0] num_in,
    input  wire logic [W-1:0] den_in,
    output logic              done,
    output logic [W-1:0]      num_out,
    output logic [W-1:0]      den_out
);
    rau_pkg::red_state_t st_reg, st_next;
    logic [W-1:0] x_reg, x_next, y_reg, y_next;
    logic [W-1:0] n_reg, n_next, d_reg, d_next;
    logic [W-1:0] g_reg, g_next;
    logic [W-1:0] dv_a, dv_b, quo, rem;
    logic         dv_start, dv_done;

    rau_divider #(.W(W)) u_div (
        .aclk(aclk), .aresetn(aresetn), .start(dv_start),
        .dividend(dv_a), .divisor(dv_b), .done(dv_done),
        .quotient(quo), .remainder(rem)
    );

    // next state; a new start is taken in the done cycle as well
    always_comb begin
        st_next = st_reg;
        unique case (st_reg)
            rau_pkg::R_IDLE:  if (start) st_next = (num_in == '0) ?
                                  rau_pkg::R_DONE : rau_pkg::R_EUC;
            rau_pkg::R_EUC:   if (x_reg == '0 || y_reg == '0) st_next = rau_pkg::R_DIVN;
                              else st_next = rau_pkg::R_DIVNW;
            rau_pkg::R_DIVNW: if (dv_done) st_next = rau_pkg::R_EUC;
            rau_pkg::R_DIVN:  st_next = rau_pkg::R_DIVD;
            rau_pkg::R_DIVD:  if (dv_done) st_next = rau_pkg::R_DIVDW;
            rau_pkg::R_DIVDW: if (dv_done) st_next = rau_pkg::R_DONE;
            rau_pkg::R_DONE:  begin
                if (start) st_next = (num_in == '0) ? rau_pkg::R_DONE : rau_pkg::R_EUC;
                else       st_next = rau_pkg::R_IDLE;
            end
            default:          st_next = rau_pkg::R_IDLE;
        endcase
    end

    // datapath / outputs; R_DIVN starts num/g, R_DIVD waits then starts den/g
    always_comb begin
        x_next   = x_reg;
        y_next   = y_reg;
        n_next   = n_reg;
        d_next   = d_reg;
        g_next   = g_reg;
        dv_start = 1'b0;
        dv_a     = n_reg;
        dv_b     = g_reg;
        unique case (st_reg)
            rau_pkg::R_IDLE, rau_pkg::R_DONE: if (start) begin
                x_next = num_in;
                y_next = den_in;
                n_next = (num_in == '0) ? '0 : num_in;
                d_next = (num_in == '0) ? W'(1) : den_in;
            end
            rau_pkg::R_EUC: begin
                if (x_reg == '0 || y_reg == '0) begin
                    g_next = (x_reg + y_reg == '0) ? W'(1) : x_reg + y_reg;
                end else begin
                    dv_start = 1'b1;
                    dv_a = (x_reg > y_reg) ? x_reg : y_reg;
                    dv_b = (x_reg > y_reg) ? y_reg : x_reg;
                end
            end
            rau_pkg::R_DIVNW: if (dv_done) begin
                if (x_reg > y_reg) x_next = rem;
                else y_next = rem;
            end
            rau_pkg::R_DIVN: begin
                dv_start = 1'b1;
                dv_a = n_reg;
                dv_b = g_reg;
            end
            rau_pkg::R_DIVD: if (dv_done) begin
                n_next   = quo;
                dv_start = 1'b1;
                dv_a     = d_reg;
                dv_b     = g_reg;
            end
            rau_pkg::R_DIVDW: if (dv_done) d_next = quo;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) st_reg <= rau_pkg::R_IDLE;
        else          st_reg <= st_next;
        x_reg <= x_next;
        y_reg <= y_next;
        n_reg <= n_next;
        d_reg <= d_next;
        g_reg <= g_next;
    end

    assign done    = (st_reg == rau_pkg::R_DONE);
    assign num_out = n_reg;
    assign den_out = d_reg;
endmodule
`default_nettype wire

[src/rational_arithmetic_unit.sv]
// Rational arithmetic unit: takes an opcode and two raw fractions, returns the
// reduced result fraction and a status. One item at a time: s_ready is high
// only when idle. An item runs three gcd reductions (operand a, operand b,
// result) on one shared 64-bit restoring divider. Each Euclid step is one
// division, and each reduction ends with two divisions by the gcd; a zero
// numerator skips its reduction. A zero input denominator returns status 1
// without any reduction, a zero divisor fraction status 2 after the operand
// reductions. The result is held in an output register until transferred;
// a new item is taken after that transfer.
// Depends on rau_pkg, rau_reducer, rau_divider and the assertion header.
`default_nettype none
`include "rational_arithmetic_unit_assert.svh"
module rational_arithmetic_unit #(
    parameter int OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [1:0]                      s_opcode,
    input  wire logic signed [OPERAND_WIDTH-1:0] s_a_num,
    input  wire logic signed [OPERAND_WIDTH-1:0] s_a_den,
    input  wire logic signed [OPERAND_WIDTH-1:0] s_b_num,
    input  wire logic signed [OPERAND_WIDTH-1:0] s_b_den,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic signed [rau_pkg::NUM_OUT_W-1:0] m_result_num,
    output logic [rau_pkg::DEN_OUT_W-1:0]        m_result_den,
    output logic [1:0]                           m_status
);
    localparam int W  = rau_pkg::DIV_W;
    localparam int OW = OPERAND_WIDTH;

    rau_pkg::seq_state_t st_reg, st_next;
    logic [1:0]   op_reg, op_next;
    logic         an_reg, an_next, bn_reg, bn_next; // operand signs
    logic [W-1:0] am_reg, am_next, ad_reg, ad_next;
    logic [W-1:0] bm_reg, bm_next, bd_reg, bd_next;
    logic         rn_reg, rn_next;
    logic [W-1:0] rm_reg, rm_next, rd_reg, rd_next;
    logic [W-1:0] mul_a_reg, mul_b_reg, mul_c_reg, mul_d_reg;
    logic [W-1:0] mul_a_next, mul_b_next, mul_c_next, mul_d_next;
    logic         form_ph_reg, form_ph_next;
    logic         ov_reg, ov_next;
    logic signed [rau_pkg::NUM_OUT_W-1:0] on_reg, on_next;
    logic [rau_pkg::DEN_OUT_W-1:0]        od_reg, od_next;
    logic [1:0]   os_reg, os_next;

    logic         r_start, r_done;
    logic [W-1:0] r_num_in, r_den_in, r_num, r_den;

    // sign/magnitude of raw operands
    logic [OW-1:0] mag_an, mag_ad, mag_bn, mag_bd;
    assign mag_an = s_a_num[OW-1] ? OW'(-s_a_num) : OW'(s_a_num);
    assign mag_ad = s_a_den[OW-1] ? OW'(-s_a_den) : OW'(s_a_den);
    assign mag_bn = s_b_num[OW-1] ? OW'(-s_b_num) : OW'(s_b_num);
    assign mag_bd = s_b_den[OW-1] ? OW'(-s_b_den) : OW'(s_b_den);

    rau_reducer #(.W(W)) u_red (
        .aclk(aclk), .aresetn(aresetn), .start(r_start),
        .num_in(r_num_in), .den_in(r_den_in), .done(r_done),
        .num_out(r_num), .den_out(r_den)
    );

    logic s_xfer, m_xfer;
    assign s_xfer = s_valid && s_ready;
    assign m_xfer = m_valid && m_ready;

    // products in the form step; operands are at most 32 bits each
    logic [W-1:0] p1, p2;
    assign p1 = mul_a_reg[31:0] * mul_b_reg[31:0];
    assign p2 = mul_c_reg[31:0] * mul_d_reg[31:0];

    logic s1, s2;
    logic [W-1:0] t1, t2;

    // next state
    always_comb begin
        st_next = st_reg;
        unique case (st_reg)
            rau_pkg::S_IDLE: if (s_xfer) begin
                st_next = (mag_ad == '0 && !s_a_den[OW-1]) ||
                          (mag_bd == '0 && !s_b_den[OW-1]) ? rau_pkg::S_OUT
                                                            : rau_pkg::S_RED_A;
            end
            rau_pkg::S_RED_A: if (r_done) st_next = rau_pkg::S_RED_B;
            rau_pkg::S_RED_B: if (r_done) begin
                st_next = (op_reg == rau_pkg::OP_DIV && r_num == '0) ?
                          rau_pkg::S_OUT : rau_pkg::S_FORM;
            end
            rau_pkg::S_FORM:  if (form_ph_reg) st_next = rau_pkg::S_RED_R;
            rau_pkg::S_RED_R: if (r_done) st_next = rau_pkg::S_OUT;
            rau_pkg::S_OUT:   if (!ov_reg || m_xfer) st_next = ov_reg ?
                                  rau_pkg::S_IDLE : rau_pkg::S_OUT;
            default:          st_next = rau_pkg::S_IDLE;
        endcase
    end

    // datapath
    always_comb begin
        op_next = op_reg; an_next = an_reg; bn_next = bn_reg;
        am_next = am_reg; ad_next = ad_reg; bm_next = bm_reg; bd_next = bd_reg;
        rn_next = rn_reg; rm_next = rm_reg; rd_next = rd_reg;
        mul_a_next = mul_a_reg; mul_b_next = mul_b_reg;
        mul_c_next = mul_c_reg; mul_d_next = mul_d_reg;
        form_ph_next = 1'b0;
        ov_next = ov_reg; on_next = on_reg; od_next = od_reg; os_next = os_reg;
        r_start = 1'b0; r_num_in = am_reg; r_den_in = ad_reg;
        t1 = p1; t2 = p2; s1 = 1'b0; s2 = 1'b0;
        if (m_xfer) ov_next = 1'b0;
        unique case (st_reg)
            rau_pkg::S_IDLE: if (s_xfer) begin
                op_next = s_opcode;
                am_next = W'(mag_an); ad_next = W'(mag_ad);
                bm_next = W'(mag_bn); bd_next = W'(mag_bd);
                // most negative value: magnitude is 2^(OW-1)
                if (s_a_num[OW-1] && mag_an == '0) am_next = W'(1) << (OW - 1);
                if (s_a_den[OW-1] && mag_ad == '0) ad_next = W'(1) << (OW - 1);
                if (s_b_num[OW-1] && mag_bn == '0) bm_next = W'(1) << (OW - 1);
                if (s_b_den[OW-1] && mag_bd == '0) bd_next = W'(1) << (OW - 1);
                an_next = (s_a_num != '0) && (s_a_num[OW-1] != s_a_den[OW-1]);
                bn_next = (s_b_num != '0) && (s_b_num[OW-1] != s_b_den[OW-1]);
                rn_next = 1'b0; rm_next = '0; rd_next = W'(1);
                os_next = ((s_a_den == '0) || (s_b_den == '0)) ?
                          rau_pkg::ST_ZDEN : rau_pkg::ST_OK;
                r_start  = 1'b1;
                r_num_in = am_next;
                r_den_in = ad_next;
                if ((s_a_den == '0) || (s_b_den == '0)) r_start = 1'b0;
            end
            rau_pkg::S_RED_A: if (r_done) begin
                am_next = r_num; ad_next = r_den;
                r_start = 1'b1; r_num_in = bm_reg; r_den_in = bd_reg;
            end
            rau_pkg::S_RED_B: if (r_done) begin
                bm_next = r_num; bd_next = r_den;
                unique case (rau_pkg::op_t'(op_reg))
                    rau_pkg::OP_MUL: begin
                        mul_a_next = am_reg; mul_b_next = r_num;
                        mul_c_next = ad_reg; mul_d_next = r_den;
                    end
                    rau_pkg::OP_DIV: begin
                        mul_a_next = am_reg; mul_b_next = r_den;
                        mul_c_next = ad_reg; mul_d_next = r_num;
                        if (r_num == '0) os_next = rau_pkg::ST_DIVZ;
                    end
                    default: begin
                        mul_a_next = am_reg; mul_b_next = r_den;
                        mul_c_next = r_num;  mul_d_next = ad_reg;
                    end
                endcase
            end
            rau_pkg::S_FORM: begin
                if (!form_ph_reg) begin
                    // phase 0: products to rm/rd (add/sub: numerator terms)
                    rm_next = p1; rd_next = p2;
                    mul_a_next = ad_reg; mul_b_next = bd_reg;
                    form_ph_next = 1'b1;
                end else begin
                    unique case (rau_pkg::op_t'(op_reg))
                        rau_pkg::OP_MUL: begin
                            rn_next = an_reg != bn_reg;
                            rm_next = rm_reg; rd_next = rd_reg;
                        end
                        rau_pkg::OP_DIV: begin
                            rn_next = an_reg != bn_reg;
                        end
                        default: begin
                            t1 = rm_reg; t2 = rd_reg;
                            s1 = (t1 == '0) ? 1'b0 : an_reg;
                            s2 = (op_reg == rau_pkg::OP_SUB) ? !bn_reg : bn_reg;
                            if (t2 == '0) s2 = 1'b0;
                            if (s1 == s2) begin
                                rn_next = s1; rm_next = t1 + t2;
                            end else if (t1 >= t2) begin
                                rn_next = s1; rm_next = t1 - t2;
                            end else begin
                                rn_next = s2; rm_next = t2 - t1;
                            end
                            rd_next = p1;
                        end
                    endcase
                    r_start  = 1'b1;
                    r_num_in = rm_next;
                    r_den_in = rd_next;
                end
            end
            rau_pkg::S_RED_R: if (r_done) begin
                rm_next = r_num; rd_next = r_den;
                if (r_num == '0) rn_next = 1'b0;
            end
            rau_pkg::S_OUT: if (!ov_reg) begin
                ov_next = 1'b1;
                if (os_reg == rau_pkg::ST_OK) begin
                    on_next = rn_reg ? -rm_reg[rau_pkg::NUM_OUT_W-1:0]
                                     : rm_reg[rau_pkg::NUM_OUT_W-1:0];
                    od_next = rd_reg[rau_pkg::DEN_OUT_W-1:0];
                end else begin
                    on_next = '0;
                    od_next = rau_pkg::DEN_OUT_W'(1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg      <= rau_pkg::S_IDLE;
            ov_reg      <= 1'b0;
            form_ph_reg <= 1'b0;
        end else begin
            st_reg      <= st_next;
            ov_reg      <= ov_next;
            form_ph_reg <= form_ph_next;
        end
        op_reg <= op_next; an_reg <= an_next; bn_reg <= bn_next;
        am_reg <= am_next; ad_reg <= ad_next; bm_reg <= bm_next; bd_reg <= bd_next;
        rn_reg <= rn_next; rm_reg <= rm_next; rd_reg <= rd_next;
        mul_a_reg <= mul_a_next; mul_b_reg <= mul_b_next;
        mul_c_reg <= mul_c_next; mul_d_reg <= mul_d_next;
        on_reg <= on_next; od_reg <= od_next; os_reg <= os_next;
    end

    assign s_ready      = (st_reg == rau_pkg::S_IDLE);
    assign m_valid      = ov_reg;
    assign m_result_num = on_reg;
    assign m_result_den = od_reg;
    assign m_status     = os_reg;

    // a held result blocks new input
    `RAU_ASSERT_IMPL(a_no_in_when_full, aclk, aresetn, m_valid |-> !s_ready,
        "input ready while result pending")
    // a bad status always comes with the zero fraction 0/1
    `RAU_ASSERT_IMPL(a_err_zero, aclk, aresetn,
        (m_valid && m_status != rau_pkg::ST_OK) |->
        (m_result_num == '0 && m_result_den == rau_pkg::DEN_OUT_W'(1)),
        "error result not 0/1")
    // reduced denominators are never zero
    `RAU_ASSERT_IMPL(a_den_nz, aclk, aresetn, m_valid |-> (m_result_den != '0),
        "zero result denominator")
    // reset leaves no result pending
    `RAU_ASSERT_RST(a_rst_clear, aclk, !aresetn |=> !m_valid,
        "result valid after reset")
endmodule
`default_nettype wire
